// ===== design/ivra_pkg.sv =====
// Shared types for the interrupt vector range allocator.
// Request and status codes, controller/datapath command and status bundles.
// No dependencies.
`default_nettype none

package ivra_pkg;

    localparam int WORD_W = 8;  // bitmap bits held in one memory word

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RESERVE = 2'd1,
        REQ_FREE    = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_COUNT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic scan_init;
        logic scan_en;
        logic mark_rd;
        logic mark_wr;
        logic set_bad;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       cnt_zero;
        logic       range_empty;
        logic       clr_last;
        logic       scan_hit;
        logic       scan_fail;
        logic       mark_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/ivra_ctrl.sv =====
// Sequencer for the allocator: clearing pass, decode, scan, mark and response.
// Depends on ivra_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module ivra_ctrl
    import ivra_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_result_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.req == REQ_ALLOC) begin
                    n_state = i_sts.cnt_zero ? S_RESP : S_SCAN;
                end else if (i_sts.req == REQ_RESERVE || i_sts.req == REQ_FREE) begin
                    n_state = i_sts.range_empty ? S_RESP : S_MARK_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit) n_state = S_MARK_RD;
                else if (i_sts.scan_fail) n_state = S_RESP;
            end
            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                n_state = i_sts.mark_last ? S_RESP : S_MARK_RD;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_DECODE: begin
                if (i_sts.req == REQ_ALLOC) begin
                    o_cmd.set_bad   = i_sts.cnt_zero;
                    o_cmd.scan_init = !i_sts.cnt_zero;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
            end
            S_RESP: begin
                o_result_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ivra_dp.sv =====
// Datapath for the allocator: bitmap memory (8 vectors a word), run scanner,
// range read-modify-write and result registers. Depends on ivra_pkg.
`default_nettype none

module ivra_dp
    import ivra_pkg::*;
#(
    parameter int NUM_VECTORS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_base_vector,
    input  wire logic [8:0] i_count,
    output t_dp_sts         o_sts,
    output logic [7:0]      o_granted_base,
    output logic [1:0]      o_status
);

    localparam int NUM_WORDS = (NUM_VECTORS + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WC_W      = $clog2(NUM_WORDS + 1);
    localparam int VI_W      = WA_W + 3;
    localparam int FW        = (VI_W > 8) ? VI_W : 8;
    localparam int END_W     = ((FW > 9) ? FW : 9) + 1;
    localparam int GB_W      = (VI_W < 8) ? VI_W : 8;

    // bitmap memory
    logic [WORD_W-1:0] r_mem [NUM_WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic              w_we;
    logic [WA_W-1:0]   w_waddr, w_raddr;
    logic [WORD_W-1:0] w_wdata;

    // request
    logic [1:0]      r_req;
    logic [FW-1:0]   r_first;
    logic [8:0]      r_len;
    logic            r_fill;
    logic [WA_W-1:0] r_mword;
    logic [WA_W-1:0] r_clr_addr;
    t_status         r_status;
    logic [7:0]      r_granted;

    // scan pipeline
    logic [WC_W-1:0] r_scan_cnt;
    logic            r_dvalid;
    logic [WA_W-1:0] r_dword;
    logic [8:0]      r_run;
    logic [VI_W-1:0] r_start;
    logic            w_issue;

    logic            w_hit;
    logic [8:0]      w_run;
    logic [VI_W-1:0] w_st, w_hs;

    logic [END_W-1:0] w_end_raw, w_end, w_end_m1;
    logic [WA_W-1:0]  w_last_word;
    logic [WORD_W-1:0] w_marked;

    assign w_issue = i_cmd.scan_en && (r_scan_cnt < WC_W'(NUM_WORDS));

    // clipped exclusive end of the range being marked
    assign w_end_raw   = END_W'(r_first) + END_W'(r_len);
    assign w_end       = (w_end_raw > END_W'(NUM_VECTORS)) ? END_W'(NUM_VECTORS) : w_end_raw;
    assign w_end_m1    = w_end - END_W'(1);
    assign w_last_word = w_end_m1[WA_W+2:3];

    // run search over one word, lowest vector first
    always_comb begin
        logic [VI_W-1:0] vidx;
        logic            free;
        w_run = r_run;
        w_st  = r_start;
        w_hit = 1'b0;
        w_hs  = r_start;
        for (int b = 0; b < WORD_W; b++) begin
            vidx = {r_dword, 3'(b)};
            free = !r_rdata[b] && (END_W'(vidx) < END_W'(NUM_VECTORS));
            if (!w_hit) begin
                if (free) begin
                    if (w_run == 9'd0) w_st = vidx;
                    w_run = w_run + 9'd1;
                    if (w_run == r_len) begin
                        w_hit = 1'b1;
                        w_hs  = w_st;
                    end
                end else begin
                    w_run = 9'd0;
                end
            end
        end
    end

    always_comb begin
        logic [END_W-1:0] vidx_e;
        for (int b = 0; b < WORD_W; b++) begin
            vidx_e = END_W'({r_mword, 3'(b)});
            if (vidx_e >= END_W'(r_first) && vidx_e < w_end) w_marked[b] = r_fill;
            else w_marked[b] = r_rdata[b];
        end
    end

    // memory port selection
    always_comb begin
        w_we    = i_cmd.clr_wr || i_cmd.mark_wr;
        w_waddr = i_cmd.clr_wr ? r_clr_addr : r_mword;
        w_wdata = i_cmd.clr_wr ? '0 : w_marked;
        w_raddr = i_cmd.mark_rd ? r_mword : r_scan_cnt[WA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_scan_cnt <= '0;
            r_dvalid   <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + WA_W'(1);
            if (i_cmd.scan_init) begin
                r_scan_cnt <= '0;
                r_dvalid   <= 1'b0;
            end else if (i_cmd.scan_en) begin
                if (w_issue) r_scan_cnt <= r_scan_cnt + WC_W'(1);
                r_dvalid <= w_issue;
            end
        end
    end

    // request, scan state and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_first   <= FW'(i_base_vector);
            r_len     <= i_count;
            r_fill    <= (i_req_type == REQ_RESERVE);
            r_mword   <= WA_W'(i_base_vector[7:3]);
            r_granted <= 8'd0;
            r_status  <= ST_OK;
        end
        if (i_cmd.set_bad) r_status <= ST_BAD_COUNT;
        if (i_cmd.scan_init) begin
            r_run   <= 9'd0;
            r_start <= '0;
        end else if (i_cmd.scan_en && r_dvalid) begin
            r_run   <= w_run;
            r_start <= w_st;
            r_dword <= r_scan_cnt[WA_W-1:0];
            if (w_hit) begin
                r_first   <= FW'(w_hs);
                r_mword   <= w_hs[VI_W-1:3];
                r_fill    <= 1'b1;
                r_granted <= 8'(w_hs[GB_W-1:0]);
                r_status  <= ST_OK;
            end else if (o_sts.scan_fail) begin
                r_status <= ST_NO_SPACE;
            end
        end else if (i_cmd.scan_en) begin
            r_dword <= r_scan_cnt[WA_W-1:0];
        end
        if (i_cmd.mark_wr) r_mword <= r_mword + WA_W'(1);
    end

    always_comb begin
        o_sts             = '0;
        o_sts.req         = r_req;
        o_sts.cnt_zero    = (r_len == 9'd0);
        o_sts.range_empty = (r_len == 9'd0) || (END_W'(r_first) >= END_W'(NUM_VECTORS));
        o_sts.clr_last    = (r_clr_addr == WA_W'(NUM_WORDS - 1));
        o_sts.scan_hit    = i_cmd.scan_en && r_dvalid && w_hit;
        o_sts.scan_fail   = i_cmd.scan_en && r_dvalid && !w_hit
                            && (r_dword == WA_W'(NUM_WORDS - 1));
        o_sts.mark_last   = (r_mword == w_last_word);
    end

    assign o_granted_base = r_granted;
    assign o_status       = r_status;

endmodule

`default_nettype wire

// ===== design/interrupt_vector_range_allocator_core.sv =====
// Interrupt vector range allocator: first-fit bitmap, 8 vectors per memory word.
// Reset: a clearing pass writes every word to free, with busy high.
// After the accepting edge the request is decoded; a bad count or unknown request goes
// straight to the strobe; reserve/free touch W words, one read and one write each;
// allocate scans S words, one per cycle through the memory port, then marks the run.
// One request at a time; the next is taken the cycle after the strobe. No output stall.
`default_nettype none

module interrupt_vector_range_allocator_core
    import ivra_pkg::*;
#(
    parameter int NUM_VECTORS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_base_vector,
    input  wire logic [8:0] i_count,
    output logic            o_result_valid,
    output logic [7:0]      o_granted_base,
    output logic [1:0]      o_status
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ivra_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    ivra_dp #(
        .NUM_VECTORS (NUM_VECTORS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (i_req_type),
        .i_base_vector  (i_base_vector),
        .i_count        (i_count),
        .o_sts          (w_sts),
        .o_granted_base (o_granted_base),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ===== design/ivra_checker.sv =====
// Port-level checks for the allocator, bound onto the top level.
// Depends on ivra_pkg for the status codes.
`default_nettype none

module ivra_checker
    import ivra_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_result_valid,
    input wire logic [7:0] o_granted_base,
    input wire logic [1:0] o_status
);

    // one strobe per transfer
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status == ST_OK || o_status == ST_NO_SPACE
                            || o_status == ST_BAD_COUNT))
        else $error("undefined status code");

    a_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |-> (o_granted_base == 8'd0))
        else $error("granted base non-zero on failure");

endmodule

bind interrupt_vector_range_allocator_core ivra_checker u_ivra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_granted_base (o_granted_base),
    .o_status       (o_status)
);

`default_nettype wire

// ===== tb/tb_interrupt_vector_range_allocator_core.sv =====
// Self-checking bench for interrupt_vector_range_allocator_core: directed and random
// allocate/reserve/free transfers, checked against a bitmap predictor held here.
// Depends on ivra_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_interrupt_vector_range_allocator_core;
    import ivra_pkg::*;

    localparam int NVEC        = 256;
    localparam int N_RANDOM    = 1950;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0] req_type;
        logic [7:0] base_vector;
        logic [8:0] count;
        bit         wait_drain;  // hold start until every grant is back
    } t_vec_req;

    typedef struct {
        logic [7:0] granted_base;
        t_status    status;
    } t_grant;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_req_type = '0;
    logic [7:0] i_base_vector = '0;
    logic [8:0] i_count = '0;
    logic       o_result_valid;
    logic [7:0] o_granted_base;
    logic [1:0] o_status;

    t_vec_req   req_q[$];
    t_grant     grant_q[$];
    bit         vec_used[NVEC];
    t_vec_req   cur_req;
    int         n_sent = 0;
    int         req_total = 0;
    int         mismatch_count = 0;
    int         stall_cycles = 0;
    int         idle_pct;

    interrupt_vector_range_allocator_core #(.NUM_VECTORS(NVEC)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_base_vector  (i_base_vector),
        .i_count        (i_count),
        .o_result_valid (o_result_valid),
        .o_granted_base (o_granted_base),
        .o_status       (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---- bitmap predictor ----
    function automatic void mark_vectors(int first, int len, bit used);
        for (int k = 0; k < len; k++) begin
            if (first + k >= NVEC) break;  // no wrap past the table
            vec_used[first + k] = used;
        end
    endfunction

    function automatic t_grant apply_request(t_vec_req r);
        t_grant g;
        int     run;
        int     run_start;
        bit     found;
        g.granted_base = '0;
        g.status       = ST_OK;
        run            = 0;
        run_start      = 0;
        found          = 1'b0;
        case (r.req_type)
            REQ_ALLOC: begin
                if (r.count == 0) begin
                    g.status = ST_BAD_COUNT;
                end else begin
                    for (int v = 0; v < NVEC; v++) begin
                        if (!vec_used[v]) begin
                            if (run == 0) run_start = v;
                            run++;
                            if (run == int'(r.count)) begin
                                found = 1'b1;
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                    if (found) begin
                        mark_vectors(run_start, r.count, 1'b1);
                        g.granted_base = run_start[7:0];
                    end else begin
                        g.status = ST_NO_SPACE;
                    end
                end
            end
            REQ_RESERVE: mark_vectors(r.base_vector, r.count, 1'b1);
            REQ_FREE:    mark_vectors(r.base_vector, r.count, 1'b0);
            default: ;
        endcase
        return g;
    endfunction

    function automatic void add_req(logic [1:0] t, int b, int c, bit drain = 1'b0);
        t_vec_req r;
        r.req_type    = t;
        r.base_vector = b[7:0];
        r.count       = c[8:0];
        r.wait_drain  = drain;
        req_q.push_back(r);
    endfunction

    // ---- driver ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                grant_q.push_back(apply_request(cur_req));
            end
            if (!start || !busy) begin
                idle_pct = (n_sent < req_total / 3) ? 36 :
                           (n_sent < 2 * req_total / 3) ? 59 : 0;
                if (req_q.size() > 0 && !(req_q[0].wait_drain && grant_q.size() > 0)
                        && $urandom_range(0, 99) >= idle_pct) begin
                    cur_req = req_q.pop_front();
                    n_sent++;
                    start         <= 1'b1;
                    i_req_type    <= cur_req.req_type;
                    i_base_vector <= cur_req.base_vector;
                    i_count       <= cur_req.count;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && o_result_valid) begin
            if (grant_q.size() == 0) begin
                $error("unexpected result: granted_base %0d status %0d",
                       o_granted_base, o_status);
                mismatch_count++;
            end else begin
                exp_g = grant_q.pop_front();
                if (o_granted_base !== exp_g.granted_base) begin
                    $error("granted_base: expected %0d, got %0d",
                           exp_g.granted_base, o_granted_base);
                    mismatch_count++;
                end
                if (o_status !== exp_g.status) begin
                    $error("status: expected %0d, got %0d", exp_g.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // ---- watchdog: cycles with no transfer on either side ----
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("interrupt_vector_range_allocator_core test failed");
        $finish;
    end

    initial begin
        int r;
        int cnt;
        int base;
        logic [1:0] t;

        // directed
        add_req(REQ_ALLOC, 0, 0);            // bad count
        add_req(REQ_ALLOC, 77, 1);           // base ignored, gets 0
        add_req(REQ_ALLOC, 0, 256);          // no space, one used
        add_req(REQ_FREE, 0, 1);
        add_req(REQ_ALLOC, 0, 256);          // whole table
        add_req(REQ_ALLOC, 0, 1);            // full
        add_req(REQ_FREE, 0, 256);
        add_req(REQ_ALLOC, 0, 511);          // larger than the table
        add_req(REQ_RESERVE, 250, 511);      // runs past the end
        add_req(REQ_ALLOC, 0, 251);          // no space
        add_req(REQ_ALLOC, 0, 250);
        add_req(REQ_FREE, 255, 511);
        add_req(REQ_ALLOC, 0, 5);            // no space, only vector 255 free
        add_req(REQ_FREE, 0, 256);
        add_req(REQ_RESERVE, 0, 0);          // zero length: no change
        add_req(REQ_FREE, 0, 0);
        add_req(REQ_RESERVE, 10, 5);
        add_req(REQ_RESERVE, 12, 5);         // overlaps used vectors
        add_req(REQ_FREE, 100, 10);          // already free
        add_req(REQ_UNKNOWN, 255, 511);      // ignored
        add_req(REQ_ALLOC, 0, 11);           // must skip the used 10..16 range
        add_req(REQ_ALLOC, 0, 10);
        add_req(REQ_RESERVE, 255, 1);
        add_req(REQ_FREE, 170, 85);
        add_req(REQ_FREE, 0, 256);

        // random, mostly small runs so the map churns
        for (int i = 0; i < N_RANDOM; i++) begin
            r    = $urandom_range(0, 99);
            base = $urandom_range(0, 255);
            if (r < 45) begin
                t   = REQ_ALLOC;
                cnt = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(0, 511);
            end else if (r < 65) begin
                t   = REQ_RESERVE;
                cnt = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 8)
                                                  : $urandom_range(0, 511);
            end else if (r < 93) begin
                t   = REQ_FREE;
                cnt = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(0, 511);
            end else if (r < 97) begin
                t   = REQ_UNKNOWN;
                cnt = $urandom_range(0, 511);
            end else begin
                t   = REQ_ALLOC;
                cnt = 0;
            end
            add_req(t, base, cnt,
                    i == 0 || i == N_RANDOM / 3 || i == 2 * N_RANDOM / 3);
        end
        req_total = req_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() > 0 || start || grant_q.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && grant_q.size() == 0)
            $display("interrupt_vector_range_allocator_core test passed");
        else
            $display("interrupt_vector_range_allocator_core test failed");
        $finish;
    end

endmodule
